// ===== rtl/decimal_literal_scanner_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Decimal literal scanner assertion macros
// Shared assertion forms for the decimal literal scanner.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LITERAL_SCANNER_UNIT_ASSERT_SVH
`define DECIMAL_LITERAL_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("decimal literal scanner assertion failed");

// Next-cycle implication, disabled during reset.
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("decimal literal scanner assertion failed");

`endif

// ===== rtl/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal literal scanner package
// Payload types, parse phases and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dls_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic is_numeric;
		logic negative_order;
		logic all_zero;
		logic too_long;
	} result_t;

	typedef enum logic [7:0] {
		PH_START     = 8'b0000_0001,
		PH_SIGN      = 8'b0000_0010,
		PH_INT       = 8'b0000_0100,
		PH_FRAC      = 8'b0000_1000,
		PH_EXP_START = 8'b0001_0000,
		PH_EXP_SIGN  = 8'b0010_0000,
		PH_EXP_DIG   = 8'b0100_0000,
		PH_ERR       = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic        nonzero;
		logic        exp_neg;
		logic        overflow;
		logic [23:0] exp_value;
	} snap_t;

	localparam logic [23:0] EXP_LIMIT = 24'd1000000;
	localparam logic [7:0]  CH_0      = 8'h30;
	localparam logic [7:0]  CH_9      = 8'h39;
	localparam logic [7:0]  CH_LOW_E  = 8'h65;
	localparam logic [7:0]  CH_UP_E   = 8'h45;
	localparam logic [7:0]  CH_DOT    = 8'h2E;
	localparam logic [7:0]  CH_PLUS   = 8'h2B;
	localparam logic [7:0]  CH_MINUS  = 8'h2D;

endpackage

`default_nettype wire

// ===== rtl/dls_scan.sv =====
// ----------------------------------------------------------------------------
// Decimal literal scanner byte stage
// Registers each byte, updates the field state and captures a snapshot
// of the finished field on its last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dls_scan #(
	parameter int MAX_FIELD_LEN = 1024,
	parameter int CNT_W         = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  dls_pkg::item_t      item_data,
	output logic                snap_valid,
	input  wire                 snap_ready,
	output dls_pkg::snap_t      snap_data,
	output logic [CNT_W-1:0]    snap_int_cnt,
	output logic [CNT_W-1:0]    snap_fnz_pos
);

	localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_FIELD_LEN);

	logic                s1_valid_q;
	dls_pkg::item_t      item_s1;
	logic                s1_fire;
	logic                snap_free;

	dls_pkg::phase_t     phase_q, phase_n, phase_scan;
	logic [CNT_W-1:0]    int_cnt_q, int_cnt_n;
	logic [CNT_W-1:0]    mant_cnt_q, mant_cnt_n;
	logic [CNT_W-1:0]    fnz_q, fnz_n;
	logic [CNT_W-1:0]    byte_cnt_q, byte_cnt_n;
	logic                nz_q, nz_n;
	logic [23:0]         exp_q, exp_n;
	logic                exp_neg_q, exp_neg_n, exp_neg_scan;
	logic                ovf_q, ovf_n;

	logic                scan_en;
	logic                dig, sgn, dot, ech;
	logic [3:0]          digit;
	logic                mant_take, int_take, exp_take;
	logic                mant_ok;

	assign snap_free  = !snap_valid || snap_ready;
	assign s1_fire    = s1_valid_q && (!item_s1.last || snap_free);
	assign item_ready = !s1_valid_q || s1_fire;

	always_comb begin
		dig   = (item_s1.char_byte >= dls_pkg::CH_0) && (item_s1.char_byte <= dls_pkg::CH_9);
		digit = dig ? item_s1.char_byte[3:0] : 4'd0;
		sgn   = (item_s1.char_byte == dls_pkg::CH_PLUS) || (item_s1.char_byte == dls_pkg::CH_MINUS);
		dot   = (item_s1.char_byte == dls_pkg::CH_DOT);
		ech   = (item_s1.char_byte == dls_pkg::CH_LOW_E) || (item_s1.char_byte == dls_pkg::CH_UP_E);
	end

	always_comb begin
		phase_scan   = phase_q;
		exp_neg_scan = exp_neg_q;
		mant_take    = 1'b0;
		int_take     = 1'b0;
		exp_take     = 1'b0;
		case (phase_q)
			dls_pkg::PH_START: begin
				if (sgn) begin
					phase_scan = dls_pkg::PH_SIGN;
				end else if (dig) begin
					mant_take  = 1'b1;
					int_take   = 1'b1;
					phase_scan = dls_pkg::PH_INT;
				end else if (dot) begin
					phase_scan = dls_pkg::PH_FRAC;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			dls_pkg::PH_SIGN: begin
				if (dig) begin
					mant_take  = 1'b1;
					int_take   = 1'b1;
					phase_scan = dls_pkg::PH_INT;
				end else if (dot) begin
					phase_scan = dls_pkg::PH_FRAC;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			dls_pkg::PH_INT: begin
				if (dig) begin
					mant_take = 1'b1;
					int_take  = 1'b1;
				end else if (dot) begin
					phase_scan = dls_pkg::PH_FRAC;
				end else if (ech) begin
					phase_scan = dls_pkg::PH_EXP_START;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			dls_pkg::PH_FRAC: begin
				if (dig) begin
					mant_take = 1'b1;
				end else if (ech && (mant_cnt_q != '0)) begin
					phase_scan = dls_pkg::PH_EXP_START;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			dls_pkg::PH_EXP_START: begin
				if (sgn) begin
					exp_neg_scan = (item_s1.char_byte == dls_pkg::CH_MINUS);
					phase_scan   = dls_pkg::PH_EXP_SIGN;
				end else if (dig) begin
					exp_take   = 1'b1;
					phase_scan = dls_pkg::PH_EXP_DIG;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			dls_pkg::PH_EXP_SIGN, dls_pkg::PH_EXP_DIG: begin
				if (dig) begin
					exp_take   = 1'b1;
					phase_scan = dls_pkg::PH_EXP_DIG;
				end else begin
					phase_scan = dls_pkg::PH_ERR;
				end
			end
			default: begin
				phase_scan = dls_pkg::PH_ERR;
			end
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		int_cnt_n  = int_cnt_q;
		mant_cnt_n = mant_cnt_q;
		fnz_n      = fnz_q;
		nz_n       = nz_q;
		exp_n      = exp_q;
		exp_neg_n  = exp_neg_q;
		byte_cnt_n = byte_cnt_q;
		ovf_n      = ovf_q;
		scan_en    = 1'b0;
		if (!ovf_q) begin
			if (byte_cnt_q == LEN_MAX) begin
				ovf_n = 1'b1;
			end else begin
				byte_cnt_n = byte_cnt_q + CNT_W'(1);
				scan_en    = 1'b1;
			end
		end
		if (scan_en) begin
			phase_n   = phase_scan;
			exp_neg_n = exp_neg_scan;
			if (mant_take) begin
				if (!nz_q && (digit != 4'd0)) begin
					fnz_n = mant_cnt_q;
					nz_n  = 1'b1;
				end
				mant_cnt_n = mant_cnt_q + CNT_W'(1);
			end
			if (int_take) begin
				int_cnt_n = int_cnt_q + CNT_W'(1);
			end
			if (exp_take && (exp_q < dls_pkg::EXP_LIMIT)) begin
				exp_n = {exp_q[20:0], 3'b000} + {exp_q[22:0], 1'b0} + {20'd0, digit};
			end
		end
		mant_ok = (phase_n == dls_pkg::PH_INT) ||
			((phase_n == dls_pkg::PH_FRAC) && (mant_cnt_n != '0)) ||
			(phase_n == dls_pkg::PH_EXP_DIG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dls_pkg::PH_START;
			int_cnt_q  <= '0;
			mant_cnt_q <= '0;
			fnz_q      <= '0;
			nz_q       <= 1'b0;
			exp_q      <= '0;
			exp_neg_q  <= 1'b0;
			byte_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (s1_fire) begin
			if (item_s1.last) begin
				phase_q    <= dls_pkg::PH_START;
				int_cnt_q  <= '0;
				mant_cnt_q <= '0;
				fnz_q      <= '0;
				nz_q       <= 1'b0;
				exp_q      <= '0;
				exp_neg_q  <= 1'b0;
				byte_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				int_cnt_q  <= int_cnt_n;
				mant_cnt_q <= mant_cnt_n;
				fnz_q      <= fnz_n;
				nz_q       <= nz_n;
				exp_q      <= exp_n;
				exp_neg_q  <= exp_neg_n;
				byte_cnt_q <= byte_cnt_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid <= 1'b0;
		end else if (snap_free) begin
			snap_valid <= s1_fire && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_free && s1_fire && item_s1.last) begin
			snap_data.valid     <= mant_ok && !ovf_n;
			snap_data.nonzero   <= nz_n;
			snap_data.exp_neg   <= exp_neg_n;
			snap_data.overflow  <= ovf_n;
			snap_data.exp_value <= exp_n;
			snap_int_cnt        <= int_cnt_n;
			snap_fnz_pos        <= fnz_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dls_result.sv =====
// ----------------------------------------------------------------------------
// Decimal literal scanner result stage
// Computes the decimal order sign from a field snapshot and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dls_result #(
	parameter int CNT_W = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 snap_valid,
	output logic                snap_ready,
	input  dls_pkg::snap_t      snap_data,
	input  wire [CNT_W-1:0]     snap_int_cnt,
	input  wire [CNT_W-1:0]     snap_fnz_pos,
	output logic                res_valid,
	input  wire                 res_ready,
	output dls_pkg::result_t    res_data
);

	localparam int OW = ((CNT_W + 1) > 25) ? (CNT_W + 3) : 27;

	logic [OW-1:0] exp_ext;
	logic [OW-1:0] order;

	assign snap_ready = !res_valid || res_ready;

	always_comb begin
		exp_ext = snap_data.exp_neg ? (OW'(0) - OW'(snap_data.exp_value)) : OW'(snap_data.exp_value);
		order   = exp_ext + OW'(snap_int_cnt) - OW'(snap_fnz_pos) - OW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (snap_ready) begin
			res_valid <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			res_data.is_numeric     <= snap_data.valid;
			res_data.negative_order <= snap_data.valid && snap_data.nonzero && order[OW-1];
			res_data.all_zero       <= snap_data.valid && !snap_data.nonzero;
			res_data.too_long       <= snap_data.overflow;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/decimal_literal_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Decimal literal scanner unit
// Validates a decimal float literal one byte per item and reports one
// result item per field on its last byte.
// ----------------------------------------------------------------------------
// Throughput is one byte item per cycle, but a last byte is held while the snapshot register is full.
// The last byte passes the byte register, the snapshot register and the result register in turn.
// Each of the three stages takes a new item whenever it is empty or moving on.
// Reset empties all stages and returns the field state to the start of a field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_literal_scanner_unit_assert.svh"

module decimal_literal_scanner_unit #(
	parameter int MAX_FIELD_LEN = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  dls_pkg::item_t      item_data,
	output logic                res_valid,
	input  wire                 res_ready,
	output dls_pkg::result_t    res_data
);

	localparam int CNT_W = $clog2(MAX_FIELD_LEN + 1);

	logic               snap_valid;
	logic               snap_ready;
	dls_pkg::snap_t     snap_data;
	logic [CNT_W-1:0]   snap_int_cnt;
	logic [CNT_W-1:0]   snap_fnz_pos;

	dls_scan #(
		.MAX_FIELD_LEN (MAX_FIELD_LEN),
		.CNT_W         (CNT_W)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap_data    (snap_data),
		.snap_int_cnt (snap_int_cnt),
		.snap_fnz_pos (snap_fnz_pos)
	);

	dls_result #(
		.CNT_W (CNT_W)
	) u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap_data    (snap_data),
		.snap_int_cnt (snap_int_cnt),
		.snap_fnz_pos (snap_fnz_pos),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_data     (res_data)
	);

	`DLS_ASSERT_NOW(a_zero_is_valid, clk, arst_n, res_valid && res_data.all_zero, res_data.is_numeric && !res_data.negative_order)
	`DLS_ASSERT_NOW(a_neg_is_valid, clk, arst_n, res_valid && res_data.negative_order, res_data.is_numeric)
	`DLS_ASSERT_NOW(a_long_invalid, clk, arst_n, res_valid && res_data.too_long, !res_data.is_numeric)
	`DLS_ASSERT_NEXT(a_snap_held, clk, arst_n, snap_valid && !snap_ready, snap_valid && $stable(snap_data))

endmodule

`default_nettype wire
